/* design/gyro_median_ema_smoother_top_assert.svh */
// assertion macros for the gyro smoother
// all macros sample on clk_i and are disabled while rst_ni is low
`ifndef GYRO_MEDIAN_EMA_SMOOTHER_TOP_ASSERT_SVH
`define GYRO_MEDIAN_EMA_SMOOTHER_TOP_ASSERT_SVH

// condition holds at every edge
`define GME_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GME_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define GME_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gme_pkg.sv */
package gme_pkg;

  // fixed field widths of the stream words
  localparam int unsigned AXES        = 3;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ALPHA_W     = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

  // per-word control from the top to every axis lane
  typedef struct packed {
    logic shift;   // new sample enters the history
    logic load;    // median register takes a new value
    logic ema;     // median moves into the smoothing stage
    logic first;   // no result given yet, median passes through
  } gme_ctrl_t;

endpackage

/* design/gme_lane.sv */
module gme_lane #(
  parameter int unsigned WINDOW      = 3,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                   clk_i,
  input  gme_pkg::gme_ctrl_t                     ctrl_i,
  input  logic signed [gme_pkg::FIELD_W-1:0]     sample_i,
  input  logic        [gme_pkg::ALPHA_W-1:0]     alpha_i,
  output logic signed [gme_pkg::FIELD_W-1:0]     smooth_o
);
  import gme_pkg::*;

  localparam int unsigned HIST = WINDOW - 1;
  localparam int unsigned RW   = $clog2(WINDOW);
  localparam logic [RW-1:0] MID = RW'(WINDOW / 2);
  localparam int unsigned PW   = SAMPLE_BITS + ALPHA_W + 2;

  logic signed [SAMPLE_BITS-1:0] cur;
  logic signed [SAMPLE_BITS-1:0] hist_q [HIST];
  logic signed [SAMPLE_BITS-1:0] elem   [WINDOW];
  logic        [RW-1:0]          rank   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] med_d, med_q;
  logic signed [SAMPLE_BITS-1:0] prev_d, prev_q;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PW-1:0]          prod;
  logic signed [SAMPLE_BITS+1:0] sum;

  // wrap or sign-extend the raw sample to the working width
  assign cur = SAMPLE_BITS'(sample_i);

  // history shift line, oldest at index 0
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < HIST - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HIST-1] <= cur;
    end
  end

  // stable rank of every window element, ties broken by position
  always_comb begin
    for (int i = 0; i < HIST; i++) begin
      elem[i] = hist_q[i];
    end
    elem[WINDOW-1] = cur;
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i) begin
          if ((elem[j] < elem[i]) || ((j < i) && (elem[j] == elem[i]))) begin
            rank[i] = rank[i] + RW'(1);
          end
        end
      end
    end
    med_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == MID) begin
        med_d = elem[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      med_q <= med_d;
    end
  end

  // ema step: prev + floor(alpha * (med - prev) / 2^16)
  assign diff = (SAMPLE_BITS+1)'(med_q) - (SAMPLE_BITS+1)'(prev_q);
  assign prod = PW'(diff) * PW'($signed({1'b0, alpha_i}));
  assign sum  = (SAMPLE_BITS+2)'(prev_q) + prod[FRAC_BITS +: SAMPLE_BITS+2];

  always_comb begin
    if (ctrl_i.first) begin
      prev_d = med_q;
    end else begin
      prev_d = sum[SAMPLE_BITS-1:0];
    end
  end

  // smoothed value doubles as this lane's output register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ema) begin
      prev_q <= prev_d;
    end
  end

  assign smooth_o = FIELD_W'(prev_q);

endmodule

/* design/gyro_median_ema_smoother_top.sv */
// channel     | dir | contents
// s_axis      | in  | tdata[95:0] = rate_x, rate_y, rate_z (signed Q16.16 each)
// m_axis      | out | tdata[95:0] = smooth_x, smooth_y, smooth_z (signed Q16.16 each)
// cfg         | in  | cfg_wdata_i = smoothing_weight (unsigned Q0.16)
//
// one word per cycle while m_axis is not stalled; a result is held first in the
// median register (rank-based median), then in the per-axis multiply-add register.
// the first WINDOW-1 words after reset fill the history and give no result.
// reset clears control and sets the weight to 6554; no clearing pass.
// a stalled output holds its word and the median stage still takes one more
// sample before s_axis_tready drops.
`include "gyro_median_ema_smoother_top_assert.svh"

module gyro_median_ema_smoother_top #(
  parameter int unsigned WINDOW      = 3,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  // rate_x [31:0], rate_y [63:32], rate_z [95:64]
  input  logic [gme_pkg::AXES*gme_pkg::FIELD_W-1:0]       s_axis_tdata,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  // smooth_x [31:0], smooth_y [63:32], smooth_z [95:64]
  output logic [gme_pkg::AXES*gme_pkg::FIELD_W-1:0]       m_axis_tdata,
  input  logic                                            cfg_we_i,
  input  logic [gme_pkg::ALPHA_W-1:0]                     cfg_wdata_i
);
  import gme_pkg::*;

  localparam int unsigned HIST = WINDOW - 1;
  localparam int unsigned CW   = $clog2(WINDOW);
  localparam logic [CW-1:0] FULL = CW'(HIST);

  logic [ALPHA_W-1:0] alpha_q;
  logic [CW-1:0]      fill_d, fill_q;
  logic               s1_valid_d, s1_valid_q;
  logic               out_valid_d, out_valid_q;
  logic               have_d, have_q;
  logic               accept, advance, full;
  gme_ctrl_t          ctrl;

  // handshake and stage movement
  assign full          = (fill_q == FULL);
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctrl.shift = accept;
  assign ctrl.load  = accept && full;
  assign ctrl.ema   = advance;
  assign ctrl.first = !have_q;

  // next-state logic for the control registers
  always_comb begin
    fill_d = fill_q;
    if (accept && !full) begin
      fill_d = fill_q + CW'(1);
    end
    s1_valid_d = s1_valid_q;
    if (ctrl.load) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    have_d = have_q || advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_RESET;
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      have_q      <= have_d;
    end
  end

  // one lane per axis, merged into the output word
  for (genvar a = 0; a < AXES; a++) begin : g_lane
    gme_lane #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .sample_i ($signed(s_axis_tdata[a*FIELD_W +: FIELD_W])),
      .alpha_i  (alpha_q),
      .smooth_o (m_axis_tdata[a*FIELD_W +: FIELD_W])
    );
  end

  assign m_axis_tvalid = out_valid_q;

  // checks
  `GME_CHECK(a_fill_range, fill_q <= FULL, "history count past window")
  `GME_IMPLY(a_load_full, ctrl.load, full, "median loaded before window full")
  `GME_IMPLY(a_no_overwrite, out_valid_q && !m_axis_tready, !advance, "stalled word overwritten")
  `GME_NEXT(a_have_set, advance, have_q && out_valid_q, "result given without first flag")

endmodule

/* tb/sv/tb.sv */
module tb;
  import gme_pkg::*;

  localparam int unsigned WINDOW      = 3;
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned CLK_HALF    = 6;
  localparam longint      RUN_LIMIT   = 64'd12 * 64'd400000;

  // one stream word, x in the low bits
  typedef struct packed {
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] x;
  } triad_t;

  logic                      clk_i;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // rate_x [31:0], rate_y [63:32], rate_z [95:64]
  logic [AXES*FIELD_W-1:0]   s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // smooth_x [31:0], smooth_y [63:32], smooth_z [95:64]
  logic [AXES*FIELD_W-1:0]   m_axis_tdata;
  logic                      cfg_we_i      = 1'b0;
  logic [ALPHA_W-1:0]        cfg_wdata_i   = '0;

  // predictor state
  longint             rate_hist[WINDOW-1][AXES];
  int unsigned        hist_fill;
  longint             last_smooth[AXES];
  bit                 smooth_started;
  logic [ALPHA_W-1:0] alpha;

  triad_t      smoothed_q[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [FIELD_W-1:0] trend[AXES];

  gyro_median_ema_smoother_top #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    #RUN_LIMIT;
    $display("== FAIL ==");
    $finish;
  end

  // median of the window per axis, then the moving average
  function automatic bit smooth_predict(input triad_t raw, output triad_t res);
    longint cur[AXES];
    longint vals[WINDOW];
    longint med[AXES];
    longint key;
    longint r;
    int     a, i, j;
    res = '0;
    for (a = 0; a < AXES; a++) begin
      cur[a] = longint'($signed(raw[a*FIELD_W +: FIELD_W]));
      if (SAMPLE_BITS < FIELD_W)
        cur[a] = (cur[a] <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
    end
    // history still filling
    if (hist_fill < WINDOW - 1) begin
      for (a = 0; a < AXES; a++)
        rate_hist[hist_fill][a] = cur[a];
      hist_fill++;
      return 1'b0;
    end
    for (a = 0; a < AXES; a++) begin
      for (i = 0; i < WINDOW - 1; i++)
        vals[i] = rate_hist[i][a];
      vals[WINDOW-1] = cur[a];
      for (i = 1; i < WINDOW; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
      med[a] = vals[WINDOW/2];
    end
    for (i = 0; i + 1 < WINDOW - 1; i++)
      for (a = 0; a < AXES; a++)
        rate_hist[i][a] = rate_hist[i+1][a];
    for (a = 0; a < AXES; a++)
      rate_hist[WINDOW-2][a] = cur[a];
    // first median passes through, later ones are blended
    for (a = 0; a < AXES; a++) begin
      if (!smooth_started)
        r = med[a];
      else
        r = last_smooth[a] +
            (((med[a] - last_smooth[a]) * longint'({48'd0, alpha})) >>> FRAC_BITS);
      last_smooth[a] = r;
      res[a*FIELD_W +: FIELD_W] = r[FIELD_W-1:0];
    end
    smooth_started = 1'b1;
    return 1'b1;
  endfunction

  // slowly drifting rate with noise, spikes and full-range words
  function automatic triad_t drift_sample();
    triad_t w;
    int     a;
    w = '0;
    for (a = 0; a < AXES; a++) begin
      case ($urandom_range(15))
        0:       w[a*FIELD_W +: FIELD_W] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        1, 2:    w[a*FIELD_W +: FIELD_W] = $urandom();
        default: w[a*FIELD_W +: FIELD_W] = trend[a] + $urandom_range(32'h4_0000) - 32'h2_0000;
      endcase
      if ($urandom_range(199) == 0)
        trend[a] = $urandom();
      else
        trend[a] = trend[a] + $urandom_range(2048) - 1024;
    end
    return w;
  endfunction

  // send one word, idling first at the chosen rate
  task automatic send_rate(input triad_t w);
    triad_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (smooth_predict(w, res))
      smoothed_q = {smoothed_q, res};
  endtask

  // stop sending until every expected word has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [ALPHA_W-1:0] w);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    alpha = w;
  endtask

  task automatic send_triad(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    triad_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    send_rate(w);
  endtask

  // history fill, median picks and the pass-through of the first median
  task automatic test_fill_median();
    send_triad(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_triad(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_triad(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_triad(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_triad(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_triad(32'haaaa_aaaa, 32'h5555_5555, 32'h0001_0000);
    send_triad(32'h5555_5555, 32'haaaa_aaaa, 32'hffff_0000);
    send_triad(32'h0000_0005, 32'h0000_0005, 32'h0000_0005);
    send_triad(32'h0000_0005, 32'hffff_fffb, 32'h0000_0005);
    send_triad(32'hffff_fffb, 32'hffff_fffb, 32'h8000_0000);
  endtask

  // weight extremes: full step, frozen output, tiny step, half step
  task automatic test_weight_extremes();
    write_weight(16'hffff);
    send_triad(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_triad(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_triad(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    write_weight(16'h0000);
    send_triad(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    send_triad(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    send_triad(32'h0000_0000, 32'hffff_ffff, 32'hedcb_a988);
    write_weight(16'h0001);
    send_triad(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_triad(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    write_weight(16'h8000);
    send_triad(32'hffff_fffd, 32'h0000_0003, 32'h8000_0001);
    send_triad(32'hffff_fffd, 32'h0000_0003, 32'h8000_0001);
    send_triad(32'h0000_0003, 32'hffff_fffd, 32'h7fff_fffe);
  endtask

  // random streams under each mix of sender idling and receiver stalls
  task automatic test_idle_phases();
    int unsigned idle_set[4]  = '{0, 48, 0, 20};
    int unsigned stall_set[4] = '{0, 0, 48, 20};
    logic [ALPHA_W-1:0] w_set[4] = '{16'hffff, 16'h0001, 16'h8000, 16'd6554};
    int p, n;
    for (p = 0; p < 4; p++) begin
      write_weight(p == 3 ? ALPHA_W'($urandom_range(16'hffff)) : w_set[p]);
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      for (n = 0; n < 460; n++)
        send_rate(drift_sample());
    end
  endtask

  // bursts with the sender waiting for the output to empty in between
  task automatic test_drain_pause();
    int b, n;
    write_weight(ALPHA_W'($urandom_range(16'hffff)));
    send_idle_pct  = 20;
    recv_stall_pct = 48;
    for (b = 0; b < 4; b++) begin
      for (n = 0; n < 25; n++)
        send_rate(drift_sample());
      drain_results();
    end
  endtask

  // compare every output word with the oldest prediction
  always @(posedge clk_i) begin : check_output
    triad_t got, want;
    int     a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (smoothed_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        error_count++;
      end else begin
        want = smoothed_q[0];
        smoothed_q.delete(0);
        for (a = 0; a < AXES; a++)
          if (got[a*FIELD_W +: FIELD_W] !== want[a*FIELD_W +: FIELD_W]) begin
            $display("%0t: axis %0d expected %h actual %h", $time, a,
                     want[a*FIELD_W +: FIELD_W], got[a*FIELD_W +: FIELD_W]);
            error_count++;
          end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    int a;
    hist_fill      = 0;
    smooth_started = 1'b0;
    alpha          = ALPHA_RESET;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (a = 0; a < AXES; a++) begin
      last_smooth[a] = 0;
      trend[a]       = $urandom_range(32'h20_0000) - 32'h10_0000;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_median();
    test_weight_extremes();
    test_idle_phases();
    test_drain_pause();

    drain_results();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/gme_pkg.sv
design/gme_lane.sv
design/gyro_median_ema_smoother_top.sv
tb/sv/tb.sv
